// ===== hdl/assert_macros.svh =====
// Assertion helpers for the radix digit emitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/rde_pkg.sv =====
package rde_pkg;

  localparam int VALUE_W  = 64;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 6;
  localparam int RADIX_W  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int CNT_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX         = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_OFFSET = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [CHAR_W-1:0]  OFFSET_RESET = 8'd87;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'd48;
  localparam logic [RADIX_W-1:0] DEC_DIGITS   = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic q_nz;
  } div_status_t;

endpackage

// ===== hdl/rde_div.sv =====
module rde_div import rde_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   dividend,
  input  logic [RADIX_W-1:0]   divisor,
  output logic [VALUE_W-1:0]   quotient,
  output logic [RADIX_W-1:0]   remainder,
  output div_status_t          status
);

  logic [VALUE_W-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r, nz_r;
  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   diff;
  logic               ge;

  // one quotient bit per cycle, MSB first; quotient shifts in behind the dividend
  assign trial   = {rem_r, q_r[VALUE_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = trial >= {1'b0, divisor};
  assign rem_nxt = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  assign q_nxt   = {q_r[VALUE_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      done_r <= (cnt_r == CNT_W'(VALUE_W - 1));
      busy_r <= (cnt_r != CNT_W'(VALUE_W - 1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
      nz_r  <= 1'b0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      nz_r  <= nz_r | ge;
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign status    = '{busy: busy_r, done: done_r, q_nz: nz_r};

endmodule

// ===== hdl/radix_digit_emitter_top.sv =====
// Per digit: a bit-serial division of the value by the radix, a done step, then an emit step
// that waits while a held output is stalled; the first division starts on the input transfer.
// A value gives N digits (at most MAX_DIGITS); the next value is stalled until the last is emitted.
// Reset (rst_n low, synchronous): idle, no output valid, radix 10, letter offset 87.
`include "assert_macros.svh"

module radix_digit_emitter_top import rde_pkg::*; #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_W-1:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic [POS_W-1:0]      out_digit_position,
  output logic                  out_last_digit,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic [CHAR_W-1:0]  offset_r;
  logic [RADIX_W-1:0] eff_radix;
  logic [POS_W-1:0]   pos_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  char_r;
  logic [POS_W-1:0]   opos_r;
  logic               olast_r;

  logic               in_xfer, slot_free, emit_go, is_last;
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend, div_quot;
  logic [RADIX_W-1:0] div_rem;
  logic [CHAR_W-1:0]  digit_char;
  div_status_t        div_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_RADIX:         radix_r  <= cfg_data[RADIX_W-1:0];
        CFG_LETTER_OFFSET: offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_radix = radix_r;
    if (radix_r < RADIX_MIN) eff_radix = RADIX_MIN;
    if (radix_r > RADIX_MAX) eff_radix = RADIX_MAX;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_go   = (state_r == ST_EMIT) && slot_free;
  assign is_last   = !div_st.q_nz || (pos_r == POS_W'(MAX_DIGITS - 1));
  assign div_start = in_xfer || (emit_go && !is_last);
  assign div_dividend = in_xfer ? in_value : div_quot;

  assign digit_char = (div_rem < DEC_DIGITS) ? CHAR_ZERO + CHAR_W'(div_rem)
                                             : offset_r + CHAR_W'(div_rem);

  rde_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (eff_radix),
    .quotient  (div_quot),
    .remainder (div_rem),
    .status    (div_st)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_DIV;
      ST_DIV:  if (div_st.done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = is_last ? ST_IDLE : ST_DIV;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) pos_r <= '0;
      else if (emit_go) pos_r <= pos_r + 1'b1;
      if (emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      char_r  <= digit_char;
      opos_r  <= pos_r;
      olast_r <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_char     = char_r;
  assign out_digit_position = opos_r;
  assign out_last_digit     = olast_r;

  `ASSERT_IMPL(a_done_in_div, clk, rst_n, div_st.done, state_r == ST_DIV)
  `ASSERT_NEXT(a_xfer_starts_div, clk, rst_n, in_xfer, state_r == ST_DIV && div_st.busy)
  `ASSERT_NEXT(a_last_to_idle, clk, rst_n, emit_go && is_last, state_r == ST_IDLE && out_valid)
  `ASSERT_IMPL(a_no_busy_idle, clk, rst_n, state_r == ST_IDLE, !div_st.busy)

endmodule
